// File: rtl/sukt_pkg.sv
// package: types, codes and sizes shared by the sorted key table modules
package sukt_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [2:0] RC_DONE      = 3'd0;
	localparam logic [2:0] RC_DUP       = 3'd1;
	localparam logic [2:0] RC_NOTFOUND  = 3'd2;
	localparam logic [2:0] RC_FULL      = 3'd3;
	localparam logic [2:0] RC_EMPTYPOS  = 3'd4;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] pid;
		logic [1:0]  status_in;
		logic [31:0] counter_in;
		logic [63:0] name_in;
		logic [3:0]  position;
	} req_t;

	typedef struct packed {
		logic [2:0]  result_code;
		logic [15:0] entry_pid;
		logic [1:0]  entry_status;
		logic [31:0] entry_counter;
		logic [63:0] entry_name;
		logic [4:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic [15:0] key;
		logic [1:0]  status;
		logic [31:0] counter;
		logic [63:0] name;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPARE,
		ST_APPLY
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic compare;
		logic apply;
	} dp_cmd_t;

endpackage

// File: rtl/sorted_unique_key_table.sv
// top level: sorted process table with unique 16-bit keys
// an accepted word passes the compare state, then the apply state
// apply waits on a stalled response; the next word can be taken during apply
// in idle, a new word is accepted while a finished response still waits to be taken
// reset: asynchronous, active low; empties the table, record contents are not cleared
module sorted_unique_key_table (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  sukt_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output sukt_pkg::rsp_t  rsp
);

	sukt_pkg::dp_cmd_t cmd;

	sukt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	sukt_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// File: rtl/sukt_ctrl.sv
// controller: sequencing of capture, compare and apply, plus response valid
module sukt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output sukt_pkg::dp_cmd_t  cmd
);

	sukt_pkg::ctrl_state_t state_q;
	sukt_pkg::ctrl_state_t state_d;
	logic                  rsp_valid_q;
	logic                  out_free;

	// the response register can take a new word this cycle
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			sukt_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = sukt_pkg::ST_COMPARE;
				end
			end
			sukt_pkg::ST_COMPARE: begin
				state_d = sukt_pkg::ST_APPLY;
			end
			sukt_pkg::ST_APPLY: begin
				if (out_free) begin
					state_d = req_valid ? sukt_pkg::ST_COMPARE : sukt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sukt_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall   = 1'b1;
		cmd.compare = 1'b0;
		cmd.apply   = 1'b0;
		case (state_q)
			sukt_pkg::ST_IDLE: begin
				req_stall = 1'b0;
			end
			sukt_pkg::ST_COMPARE: begin
				cmd.compare = 1'b1;
			end
			sukt_pkg::ST_APPLY: begin
				cmd.apply = out_free;
				req_stall = !out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
		cmd.capture = req_valid && !req_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sukt_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.apply) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

`ifndef ASSERT_OFF
	a_rsp_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == sukt_pkg::ST_APPLY))
		else $error("response valid rose without an apply cycle");

	a_accept_to_compare: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == sukt_pkg::ST_COMPARE))
		else $error("accepted word not followed by compare");

	a_compare_to_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sukt_pkg::ST_COMPARE) |=> (state_q == sukt_pkg::ST_APPLY))
		else $error("compare not followed by apply");
`endif

endmodule

// File: rtl/sukt_dp.sv
// datapath: sorted record registers, parallel key compare and shift network
module sukt_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  sukt_pkg::dp_cmd_t  cmd,
	input  sukt_pkg::req_t     req,
	output sukt_pkg::rsp_t     rsp
);

	sukt_pkg::req_t                      req_q;
	sukt_pkg::entry_t                    tbl_q [sukt_pkg::CAPACITY];
	sukt_pkg::entry_t                    tbl_d [sukt_pkg::CAPACITY];
	sukt_pkg::entry_t                    ins_tbl [sukt_pkg::CAPACITY];
	sukt_pkg::entry_t                    rem_tbl [sukt_pkg::CAPACITY];
	sukt_pkg::entry_t                    new_entry;
	sukt_pkg::entry_t                    rd_entry;
	logic [sukt_pkg::CNT_W-1:0]          fill_q;
	logic [sukt_pkg::CNT_W-1:0]          fill_d;
	logic [sukt_pkg::CAPACITY-1:0]       lt_q;
	logic [sukt_pkg::CAPACITY-1:0]       eq_q;
	logic                                hit;
	sukt_pkg::rsp_t                      rsp_d;
	sukt_pkg::rsp_t                      rsp_q;

	assign new_entry.key     = req_q.pid;
	assign new_entry.status  = req_q.status_in;
	assign new_entry.counter = req_q.counter_in;
	assign new_entry.name    = req_q.name_in;
	assign hit               = |eq_q;

	// held keys are sorted, so the below-key mask is a run of ones from slot zero
	genvar j;
	generate
		for (j = 0; j < sukt_pkg::CAPACITY; j++) begin : g_slot
			if (j == 0) begin : g_first
				assign ins_tbl[j] = lt_q[j] ? tbl_q[j] : new_entry;
			end else begin : g_rest
				assign ins_tbl[j] = lt_q[j] ? tbl_q[j] :
					(lt_q[j-1] ? new_entry : tbl_q[j-1]);
			end
			if (j == sukt_pkg::CAPACITY - 1) begin : g_last
				assign rem_tbl[j] = tbl_q[j];
			end else begin : g_lower
				assign rem_tbl[j] = lt_q[j] ? tbl_q[j] : tbl_q[j+1];
			end
		end
	endgenerate

	always_comb begin
		tbl_d    = tbl_q;
		fill_d   = fill_q;
		rd_entry = tbl_q[sukt_pkg::IDX_W'(req_q.position)];
		rsp_d    = '0;
		rsp_d.result_code = sukt_pkg::RC_DONE;
		case (req_q.operation)
			sukt_pkg::OP_INSERT: begin
				if (hit) begin
					rsp_d.result_code = sukt_pkg::RC_DUP;
				end else if (int'(fill_q) >= sukt_pkg::CAPACITY) begin
					rsp_d.result_code = sukt_pkg::RC_FULL;
				end else begin
					tbl_d  = ins_tbl;
					fill_d = fill_q + sukt_pkg::CNT_W'(1);
				end
			end
			sukt_pkg::OP_REMOVE: begin
				if (hit) begin
					tbl_d  = rem_tbl;
					fill_d = fill_q - sukt_pkg::CNT_W'(1);
				end else begin
					rsp_d.result_code = sukt_pkg::RC_NOTFOUND;
				end
			end
			sukt_pkg::OP_READ: begin
				if (int'(req_q.position) < int'(fill_q)) begin
					rsp_d.entry_pid     = rd_entry.key;
					rsp_d.entry_status  = rd_entry.status;
					rsp_d.entry_counter = rd_entry.counter;
					rsp_d.entry_name    = rd_entry.name;
				end else begin
					rsp_d.result_code = sukt_pkg::RC_EMPTYPOS;
				end
			end
			default: begin
				rsp_d.result_code = sukt_pkg::RC_DONE;
			end
		endcase
		rsp_d.entry_count = 5'(fill_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.apply) begin
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.compare) begin
			for (int i = 0; i < sukt_pkg::CAPACITY; i++) begin
				lt_q[i] <= (i < int'(fill_q)) && (tbl_q[i].key < req_q.pid);
				eq_q[i] <= (i < int'(fill_q)) && (tbl_q[i].key == req_q.pid);
			end
		end
		if (cmd.apply) begin
			tbl_q <= tbl_d;
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= sukt_pkg::CAPACITY)
		else $error("fill level above capacity");

	a_keys_unique: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> $onehot0(eq_q))
		else $error("more than one held key matches");

	a_keys_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> ((lt_q & (lt_q + 1'b1)) == '0))
		else $error("below-key mask is not a prefix, table out of order");
`endif

endmodule
